// File: rtl/vpo_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the triangle table of the vibrato pitch oscillator.
// Used by the controller, the datapath and the top level; depends on nothing.
package vpo_pkg;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned OUT_USER_W = 1;

	localparam logic [7:0] DELAY_LIMIT = 8'd100;
	localparam logic [3:0] DIV_LAST    = 4'd15;

	typedef enum logic [2:0] {
		ACT_SET_VIBRATO = 3'd0,
		ACT_SET_FADE    = 3'd1,
		ACT_NOTE_START  = 3'd2,
		ACT_TICK        = 3'd3,
		ACT_SUB_TICK    = 3'd4
	} vpo_action_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_init;
		logic div_step;
		logic adv;
		logic mul;
		logic fin;
		logic out_load;
	} vpo_cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       fade_nz;
		logic       div_last;
		logic       wrap;
	} vpo_status_t;

	function automatic logic [7:0] tri_wave(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'h00;
			5'd1:  v = 8'h20;
			5'd2:  v = 8'h38;
			5'd3:  v = 8'h50;
			5'd4:  v = 8'h68;
			5'd5:  v = 8'h80;
			5'd6:  v = 8'h90;
			5'd7:  v = 8'hA0;
			5'd8:  v = 8'hB0;
			5'd9:  v = 8'hC0;
			5'd10: v = 8'hD0;
			5'd11: v = 8'hE0;
			5'd12: v = 8'hE8;
			5'd13: v = 8'hF0;
			5'd14: v = 8'hF8;
			5'd15: v = 8'hFC;
			5'd16: v = 8'hFF;
			5'd17: v = 8'hFC;
			5'd18: v = 8'hF8;
			5'd19: v = 8'hF0;
			5'd20: v = 8'hE8;
			5'd21: v = 8'hE0;
			5'd22: v = 8'hD0;
			5'd23: v = 8'hC0;
			5'd24: v = 8'hB0;
			5'd25: v = 8'hA0;
			5'd26: v = 8'h90;
			5'd27: v = 8'h80;
			5'd28: v = 8'h68;
			5'd29: v = 8'h50;
			5'd30: v = 8'h38;
			5'd31: v = 8'h20;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/vpo_datapath.sv
`timescale 1ns / 1ps
// Datapath of the vibrato pitch oscillator: channel state, serial divider,
// phase accumulator, depth scaling multiplier and output word register. Uses vpo_pkg.
module vpo_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vpo_pkg::vpo_cmd_t    cmd,
	output vpo_pkg::vpo_status_t sts,
	input  logic [31:0]          in_tdata,
	input  logic [2:0]           in_tuser,
	output logic [15:0]          out_tdata,
	output logic [0:0]           out_tuser
);
	import vpo_pkg::*;

	logic [2:0]  action_q;
	logic [7:0]  dly_q, rt_q, dep_q, fad_q;

	logic [7:0]  planned_delay_q, planned_fade_q, phase_rate_q;
	logic [4:0]  phase_step_q;
	logic [15:0] depth_goal_q, depth_increment_q, current_depth_q;
	logic [7:0]  delay_left_q, fade_left_q;
	logic [7:0]  rate_acc_q;
	logic [5:0]  wave_phase_q;
	logic [15:0] offset_q;
	logic        go_q, changed_q;

	logic [7:0]  rem_q;
	logic [15:0] quo_q;
	logic [3:0]  div_cnt_q;
	logic [15:0] mag_q;

	logic [8:0]  trial;
	logic        trial_ge;
	logic [7:0]  trial_rem;
	logic [15:0] quo_next;
	logic [8:0]  acc_sum;
	logic [5:0]  phase_next;
	logic [8:0]  scale;
	logic [16:0] product;
	logic [7:0]  rate_dec;
	logic [4:0]  step_dec;

	always_comb begin
		trial     = {rem_q, quo_q[15]};
		trial_ge  = trial >= {1'b0, planned_fade_q};
		trial_rem = trial_ge ? 8'(trial - {1'b0, planned_fade_q}) : trial[7:0];
		quo_next  = {quo_q[14:0], trial_ge};
		acc_sum    = {1'b0, rate_acc_q} + {1'b0, phase_rate_q};
		phase_next = wave_phase_q + 6'(phase_step_q);
		if (current_depth_q[15] == 1'b0) begin
			scale   = current_depth_q[15:7];
		end else begin
			scale   = {2'b00, current_depth_q[14:8]} + 9'd2;
		end
		product = {9'd0, tri_wave(wave_phase_q[4:0])} * {8'd0, scale};
	end

	always_comb begin
		if (rt_q < 8'h20) begin
			rate_dec = {rt_q[4:0], 3'b000};
			step_dec = 5'd1;
		end else if (rt_q < 8'h40) begin
			rate_dec = {rt_q[5:0], 2'b00};
			step_dec = 5'd2;
		end else if (rt_q < 8'h80) begin
			rate_dec = {rt_q[6:0], 1'b0};
			step_dec = 5'd4;
		end else if (rt_q != 8'hFF) begin
			rate_dec = rt_q;
			step_dec = 5'd8;
		end else begin
			rate_dec = 8'hFF;
			step_dec = 5'd16;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_tuser;
			dly_q    <= in_tdata[7:0];
			rt_q     <= in_tdata[15:8];
			dep_q    <= in_tdata[23:16];
			fad_q    <= in_tdata[31:24];
		end
		if (cmd.div_init) begin
			rem_q     <= 8'd0;
			quo_q     <= depth_goal_q;
			div_cnt_q <= 4'd0;
		end else if (cmd.div_step) begin
			rem_q     <= trial_rem;
			quo_q     <= quo_next;
			div_cnt_q <= div_cnt_q + 4'd1;
		end
		if (cmd.mul) begin
			mag_q <= current_depth_q[15] ? product[16:1] : {7'd0, product[16:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planned_delay_q   <= '0;
			planned_fade_q    <= '0;
			phase_rate_q      <= '0;
			phase_step_q      <= '0;
			depth_goal_q      <= '0;
			depth_increment_q <= '0;
			delay_left_q      <= '0;
			fade_left_q       <= '0;
			current_depth_q   <= '0;
			rate_acc_q        <= '0;
			wave_phase_q      <= '0;
			offset_q          <= '0;
			go_q              <= 1'b0;
			changed_q         <= 1'b0;
			out_tdata         <= '0;
			out_tuser         <= '0;
		end else begin
			if (cmd.capture) begin
				changed_q <= 1'b0;
			end
			if (cmd.exec) begin
				go_q <= (delay_left_q == 8'd0);
				case (action_q)
					ACT_SET_VIBRATO: begin
						if (dly_q < DELAY_LIMIT) begin
							planned_delay_q <= dly_q;
						end else begin
							planned_delay_q <= 8'd0;
							planned_fade_q  <= dly_q - DELAY_LIMIT;
						end
						phase_rate_q <= rate_dec;
						phase_step_q <= step_dec;
						depth_goal_q <= {dep_q, 8'd0};
					end
					ACT_SET_FADE: begin
						planned_fade_q <= fad_q;
					end
					ACT_NOTE_START: begin
						delay_left_q    <= planned_delay_q;
						fade_left_q     <= planned_fade_q;
						current_depth_q <= (planned_fade_q == 8'd0) ? depth_goal_q : 16'd0;
						rate_acc_q      <= 8'd0;
						wave_phase_q    <= 6'd0;
					end
					ACT_TICK: begin
						if (delay_left_q == 8'd0) begin
							if (fade_left_q != 8'd0) begin
								fade_left_q <= fade_left_q - 8'd1;
								if (fade_left_q == 8'd1) begin
									current_depth_q <= depth_goal_q;
								end else begin
									current_depth_q <= current_depth_q + depth_increment_q;
								end
							end
						end else begin
							delay_left_q <= delay_left_q - 8'd1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.div_step && div_cnt_q == DIV_LAST) begin
				depth_increment_q <= quo_next;
			end
			if (cmd.adv && go_q) begin
				rate_acc_q <= acc_sum[7:0];
				if (acc_sum[8]) begin
					wave_phase_q <= phase_next;
				end
			end
			if (cmd.fin) begin
				offset_q  <= wave_phase_q[5] ? 16'(16'd0 - mag_q) : mag_q;
				changed_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_tdata <= offset_q;
				out_tuser <= changed_q;
			end
		end
	end

	assign sts.action   = action_q;
	assign sts.fade_nz  = (planned_fade_q != 8'd0);
	assign sts.div_last = (div_cnt_q == DIV_LAST);
	assign sts.wrap     = go_q & acc_sum[8];

endmodule

// File: rtl/vpo_ctrl.sv
`timescale 1ns / 1ps
// Controller of the vibrato pitch oscillator: sequences one command word through
// the datapath and drives both handshakes. Uses vpo_pkg.
module vpo_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  vpo_pkg::vpo_status_t sts,
	output vpo_pkg::vpo_cmd_t    cmd
);
	import vpo_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV_INIT,
		ST_DIV,
		ST_ADV,
		ST_MUL,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.div_init = (state_q == ST_DIV_INIT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.adv      = (state_q == ST_ADV);
		cmd.mul      = (state_q == ST_MUL);
		cmd.fin      = (state_q == ST_FIN);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			m_tvalid <= cmd.out_load || (m_tvalid && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (sts.action == ACT_SET_VIBRATO || sts.action == ACT_SET_FADE) begin
						state_q <= ST_DIV_INIT;
					end else if (sts.action == ACT_TICK || sts.action == ACT_SUB_TICK) begin
						state_q <= ST_ADV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV_INIT: begin
					state_q <= sts.fade_nz ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_ADV: begin
					state_q <= sts.wrap ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/vibrato_pitch_oscillator.sv
`timescale 1ns / 1ps
// Top level of the single-channel vibrato pitch oscillator.
// Instantiates vpo_ctrl and vpo_datapath; uses vpo_pkg.
//
// The slave channel takes one command word at a time: s_tuser carries the action
// (set vibrato, set fade length, note start, tick, sub-tick) and s_tdata carries the
// delay, rate, depth and fade bytes. Every command word yields exactly one result
// word on the master channel: m_tdata is the signed pitch offset in force after the
// command, m_tuser is set when that command recomputed the offset.
// A note start or an unused action goes straight to the result register. A tick or
// sub-tick passes through the accumulator and, if it steps the phase, through the
// depth multiplier and the sign step. Set vibrato or set fade length with a nonzero
// fade length runs a restoring divider for the depth step that retires one quotient
// bit per cycle of its 16-bit quotient. The next word is accepted only once the
// result is loaded.
// The result register lets the next command word be accepted and processed while a
// result waits; if the receiver stalls, the finished result is held until the
// register frees up, and the slave channel stays closed until then.
// Reset clears all channel state, so the offset reads zero until the phase steps.
module vibrato_pitch_oscillator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // delay_byte, rate_byte, depth_byte, fade_byte
	input  logic [2:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // pitch_offset
	output logic [0:0]  m_tuser   // pitch_changed
);
	import vpo_pkg::*;

	vpo_cmd_t    cmd;
	vpo_status_t sts;

	vpo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vpo_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.out_tdata (m_tdata),
		.out_tuser (m_tuser)
	);

endmodule

// File: rtl/vpo_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the vibrato pitch oscillator and its bind to the top level.
// Depends only on the top level's ports.
module vpo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_hold_valid : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result word dropped while stalled.");

	a_hold_data : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("Result word changed while stalled.");

	a_one_at_a_time : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Second command word accepted while one is in progress.");

	a_offset_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= 16'sd16447) && ($signed(m_tdata) >= -16'sd16447))
		else $error("Pitch offset out of range.");

	a_reset_idle : assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("Result word valid during reset.");

endmodule

bind vibrato_pitch_oscillator vpo_checker u_vpo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
